// File: rtl/dmwc_pkg.sv
// shared types and constants of the direct-mapped write-back cache
package dmwc_pkg;

   localparam int ADDR_W      = 16;
   localparam int DATA_W      = 8;
   localparam int LINE_DATA_W = 64;

   localparam logic ACT_READ  = 1'b0;
   localparam logic ACT_WRITE = 1'b1;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
   } req_type;

   typedef struct packed {
      logic [LINE_DATA_W-1:0] line_data;
      logic                   hit;
      logic                   dirty_before;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITEBACK,
      ST_FILL,
      ST_FILL_WAIT,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic clear;
      logic lookup;
      logic capture_entry;
      logic writeback;
      logic fill_read;
      logic fill_capture;
      logic update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic hit;
      logic dirty;
      logic is_write;
   } status_type;

endpackage

// File: rtl/dmwc_ram.sv
// single-port synchronous ram with registered read data
module dmwc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/dmwc_ctrl.sv
// controller state machine of the cache: sequencing, handshakes, response valid
module dmwc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  dmwc_pkg::status_type status,
   output dmwc_pkg::cmd_type    cmd
);
   import dmwc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (status.hit)        state_in = ST_UPDATE;
            else if (status.dirty) state_in = ST_WRITEBACK;
            else                   state_in = ST_FILL;
         end
         ST_WRITEBACK: state_in = ST_FILL;
         ST_FILL:      state_in = ST_FILL_WAIT;
         ST_FILL_WAIT: state_in = ST_UPDATE;
         ST_UPDATE: begin
            if (status.is_write || slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.lookup = req_valid;
         end
         ST_LOOKUP:    cmd.capture_entry = 1'b1;
         ST_WRITEBACK: cmd.writeback = 1'b1;
         ST_FILL:      cmd.fill_read = 1'b1;
         ST_FILL_WAIT: cmd.fill_capture = 1'b1;
         ST_UPDATE: begin
            cmd.update   = status.is_write || slot_free;
            cmd.load_rsp = !status.is_write && slot_free;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)       rsp_valid_in = 1'b1;
      else if (!rsp_stall)    rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_then_busy : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request transfer taken while previous item still in flight");

   a_no_rsp_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response register overwritten before transfer");

   a_rsp_from_update : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_UPDATE))
      else $error("response raised outside the update step");

   a_no_write_rsp : assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && status.is_write) == 1'b0)
      else $error("write access produced a response");
`endif

endmodule

// File: rtl/dmwc_datapath.sv
// datapath of the cache: request registers, cache and backing rams, response register
module dmwc_datapath #(
   parameter int NUM_LINES      = 64,
   parameter int BYTES_PER_LINE = 8,
   parameter int MEMORY_BLOCKS  = 8192
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dmwc_pkg::req_type    req_payload,
   input  dmwc_pkg::cmd_type    cmd,
   output dmwc_pkg::status_type status,
   output dmwc_pkg::rsp_type    rsp_payload
);
   import dmwc_pkg::*;

   localparam int OFF_W     = $clog2(BYTES_PER_LINE);
   localparam int IDX_W     = $clog2(NUM_LINES);
   localparam int TAG_RAW   = ADDR_W - OFF_W - IDX_W;
   localparam int TAG_W     = (TAG_RAW < 1) ? 1 : TAG_RAW;
   localparam int AX_W      = OFF_W + IDX_W + TAG_W;
   localparam int LINE_W    = 8 * BYTES_PER_LINE;
   localparam int ENT_W     = 1 + TAG_W + LINE_W;
   localparam int MEM_W     = $clog2(MEMORY_BLOCKS);
   localparam int CLR_DEPTH = (MEMORY_BLOCKS > NUM_LINES) ? MEMORY_BLOCKS : NUM_LINES;
   localparam int CLR_W     = $clog2(CLR_DEPTH);
   localparam logic [CLR_W-1:0] CLR_LAST  = CLR_W'(CLR_DEPTH - 1);
   localparam logic [CLR_W:0]   LINES_LIM = (CLR_W+1)'(NUM_LINES);
   localparam logic [CLR_W:0]   MEM_LIM   = (CLR_W+1)'(MEMORY_BLOCKS);

   // request registers
   logic              action_ff;
   logic [ADDR_W-1:0] address_ff;
   logic [DATA_W-1:0] wdata_ff;
   // entry as read from the cache, line replaced on fill
   logic [LINE_W-1:0] line_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              dirty_ff;
   logic              hit_ff;
   rsp_type           rsp_ff;
   logic [CLR_W-1:0]  clear_cnt_ff;

   logic [AX_W-1:0]   req_ax, cur_ax;
   logic [IDX_W-1:0]  req_idx, cur_idx;
   logic [TAG_W-1:0]  cur_tag;
   logic [OFF_W-1:0]  cur_off;

   logic              cache_we;
   logic [IDX_W-1:0]  cache_addr;
   logic [ENT_W-1:0]  cache_wdata, cache_rdata;
   logic              mem_we;
   logic [MEM_W-1:0]  mem_addr;
   logic [LINE_W-1:0] mem_wdata, mem_rdata;

   logic [TAG_W-1:0]  rd_tag;
   logic              rd_dirty;
   logic [LINE_W-1:0] rd_line;
   logic [LINE_W-1:0] merged_line;
   logic              dirty_new;
   logic [MEM_W-1:0]  victim_blk, fill_blk;

   assign req_ax  = AX_W'(req_payload.address);
   assign req_idx = req_ax[OFF_W +: IDX_W];
   assign cur_ax  = AX_W'(address_ff);
   assign cur_off = cur_ax[OFF_W-1:0];
   assign cur_idx = cur_ax[OFF_W +: IDX_W];
   assign cur_tag = cur_ax[AX_W-1 -: TAG_W];

   assign rd_dirty = cache_rdata[ENT_W-1];
   assign rd_tag   = cache_rdata[ENT_W-2 -: TAG_W];
   assign rd_line  = cache_rdata[LINE_W-1:0];

   // block number wraps modulo the memory depth
   assign victim_blk = MEM_W'({tag_ff, cur_idx});
   assign fill_blk   = MEM_W'({cur_tag, cur_idx});

   always_comb begin
      merged_line = line_ff;
      for (int k = 0; k < BYTES_PER_LINE; k++) begin
         if (action_ff == ACT_WRITE && cur_off == OFF_W'(k)) begin
            merged_line[8*k +: 8] = wdata_ff;
         end
      end
   end

   assign dirty_new = (action_ff == ACT_WRITE) ? 1'b1 : (hit_ff && dirty_ff);

   // cache ram port
   always_comb begin
      if (cmd.clear) begin
         cache_addr  = clear_cnt_ff[IDX_W-1:0];
         cache_we    = ({1'b0, clear_cnt_ff} < LINES_LIM);
         cache_wdata = '0;
      end else begin
         cache_addr  = cmd.lookup ? req_idx : cur_idx;
         cache_we    = cmd.update;
         cache_wdata = {dirty_new, cur_tag, merged_line};
      end
   end

   // backing memory port
   always_comb begin
      if (cmd.clear) begin
         mem_addr  = clear_cnt_ff[MEM_W-1:0];
         mem_we    = ({1'b0, clear_cnt_ff} < MEM_LIM);
         mem_wdata = '0;
      end else begin
         mem_addr  = cmd.writeback ? victim_blk : fill_blk;
         mem_we    = cmd.writeback;
         mem_wdata = line_ff;
      end
   end

   dmwc_ram #(.WIDTH(ENT_W), .DEPTH(NUM_LINES)) u_cache_ram (
      .clock (clock),
      .we    (cache_we),
      .addr  (cache_addr),
      .wdata (cache_wdata),
      .rdata (cache_rdata)
   );

   dmwc_ram #(.WIDTH(LINE_W), .DEPTH(MEMORY_BLOCKS)) u_mem_ram (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else if (cmd.clear) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         action_ff  <= req_payload.action;
         address_ff <= req_payload.address;
         wdata_ff   <= req_payload.write_data;
      end
      if (cmd.capture_entry) begin
         line_ff  <= rd_line;
         tag_ff   <= rd_tag;
         dirty_ff <= rd_dirty;
         hit_ff   <= (rd_tag == cur_tag);
      end else if (cmd.fill_capture) begin
         line_ff <= mem_rdata;
      end
      if (cmd.load_rsp) begin
         rsp_ff.line_data    <= LINE_DATA_W'(line_ff);
         rsp_ff.hit          <= hit_ff;
         rsp_ff.dirty_before <= dirty_ff;
      end
   end

   assign status.clear_last = (clear_cnt_ff == CLR_LAST);
   assign status.hit        = (rd_tag == cur_tag);
   assign status.dirty      = rd_dirty;
   assign status.is_write   = (action_ff == ACT_WRITE);
   assign rsp_payload       = rsp_ff;

endmodule

// File: rtl/direct_mapped_writeback_cache_top.sv
// top level of the direct-mapped write-back write-allocate byte cache
//
// usage:
//   req channel (req_valid, req_stall, req_payload): one access per transfer,
//   a read or a one-byte write at a 16-bit byte address.
//   rsp channel (rsp_valid, rsp_stall, rsp_payload): one transfer per read,
//   carrying the line, the hit flag and the dirty mark before the access;
//   writes give no response.
//   one access is in service at a time; each access goes through single-port
//   cache and backing rams with registered reads.
//   steps per access: a hit does lookup and update; a clean miss adds the fill
//   read and fill capture; a dirty miss also does a write-back before them.
//   a read response appears in the cycle after its update step.
//   the response sits in an output register; while rsp_stall holds it, the
//   next access may still be taken; a read is held in its update step until the
//   register is free, a write is not.
//   after reset a clearing pass zeroes both rams, stepping through
//   max(MEMORY_BLOCKS, NUM_LINES) addresses, with req_stall high throughout.
//   NUM_LINES, BYTES_PER_LINE and MEMORY_BLOCKS must be powers of two; the block does not check this.
module direct_mapped_writeback_cache_top #(
   parameter int NUM_LINES      = 64,
   parameter int BYTES_PER_LINE = 8,
   parameter int MEMORY_BLOCKS  = 8192
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dmwc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dmwc_pkg::rsp_type rsp_payload
);
   import dmwc_pkg::*;

   cmd_type    cmd;
   status_type status;

   dmwc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   dmwc_datapath #(
      .NUM_LINES      (NUM_LINES),
      .BYTES_PER_LINE (BYTES_PER_LINE),
      .MEMORY_BLOCKS  (MEMORY_BLOCKS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// testbench of the direct-mapped write-back cache: directed table, random traffic, scoreboard
module tb_top;
   import dmwc_pkg::*;

   localparam int RANDOM_ACCESSES = 1400;
   localparam int QUIET_TAIL      = 200;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DIRECTED_ROWS   = 25;

   typedef struct packed {
      logic        action;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic        fixed;
      logic [63:0] line_data;
      logic        hit;
      logic        dirty_before;
   } access_row_type;

   logic    clock;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   bit [6:0]  shadow_tags   [64];
   bit        shadow_dirty  [64];
   bit [63:0] shadow_lines  [64];
   bit [63:0] shadow_memory [8192];

   rsp_type pending_reads [$];
   int      mismatch_count = 0;
   int      cycle_count    = 0;
   bit      idling_on      = 1'b0;

   // fixed rows carry their read response; the rest take theirs from the shadow model
   access_row_type directed_rows [DIRECTED_ROWS] = '{
      {ACT_READ,  16'h0000, 8'h00, 1'b1, 64'h0000000000000000, 1'b1, 1'b0},
      {ACT_READ,  16'hFFFF, 8'h00, 1'b1, 64'h0000000000000000, 1'b0, 1'b0},
      {ACT_WRITE, 16'hFFFF, 8'hFF, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'hFFF8, 8'h00, 1'b1, 64'hFF00000000000000, 1'b1, 1'b1},
      {ACT_WRITE, 16'h01F8, 8'hA5, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'hFFFF, 8'h00, 1'b1, 64'hFF00000000000000, 1'b0, 1'b1},
      {ACT_READ,  16'h01F8, 8'h00, 1'b1, 64'h00000000000000A5, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1230, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1231, 8'h11, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1232, 8'h22, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1233, 8'h33, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1234, 8'h44, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1235, 8'h55, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1236, 8'h66, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h1237, 8'hFF, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'h1237, 8'h00, 1'b1, 64'hFF66554433221100, 1'b1, 1'b1},
      {ACT_READ,  16'h0030, 8'h00, 1'b1, 64'h0000000000000000, 1'b0, 1'b1},
      {ACT_READ,  16'h1230, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h8000, 8'h7E, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'h8000, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'h0000, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'hAAAA, 8'h55, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_WRITE, 16'h5555, 8'hAA, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'hAAAA, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0},
      {ACT_READ,  16'h5555, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0}
   };

   direct_mapped_writeback_cache_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] got);
      $display("mismatch %s: expected %h got %h", what, want, got);
      mismatch_count++;
   endtask

   task automatic predict_access(input req_type access, output bit gives_rsp,
                                 output rsp_type line_rsp);
      bit [2:0] offset;
      bit [5:0] index;
      bit [6:0] tag;
      bit       tag_match;
      bit       was_dirty;
      offset    = access.address[2:0];
      index     = access.address[8:3];
      tag       = access.address[15:9];
      tag_match = (shadow_tags[index] == tag);
      was_dirty = shadow_dirty[index];
      line_rsp  = '0;
      if (!tag_match) begin
         if (was_dirty)
            shadow_memory[{shadow_tags[index], index}] = shadow_lines[index];
         shadow_lines[index] = shadow_memory[{tag, index}];
         shadow_tags[index]  = tag;
      end
      if (access.action == ACT_WRITE) begin
         shadow_dirty[index] = 1'b1;
         shadow_lines[index][offset*8 +: 8] = access.write_data;
         gives_rsp = 1'b0;
      end else begin
         if (!tag_match)
            shadow_dirty[index] = 1'b0;
         gives_rsp             = 1'b1;
         line_rsp.line_data    = shadow_lines[index];
         line_rsp.hit          = tag_match;
         line_rsp.dirty_before = was_dirty;
      end
   endtask

   // call it in step with the clock; it returns in step with the clock, once the request has been taken
   task automatic send_access(input req_type access, input bit fixed,
                              input rsp_type fixed_rsp);
      bit      gives_rsp;
      rsp_type line_rsp;
      req_valid   <= 1'b1;
      req_payload <= access;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predict_access(access, gives_rsp, line_rsp);
      if (gives_rsp)
         pending_reads.push_back(fixed ? fixed_rsp : line_rsp);
   endtask

   function automatic req_type random_access();
      req_type access;
      access.action     = 1'($urandom_range(0, 1));
      access.write_data = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) == 0) begin
         access.address = 16'($urandom_range(0, 65535));
      end else begin
         access.address[15:9] = ($urandom_range(0, 9) < 7) ? 7'($urandom_range(0, 3))
                                                            : 7'($urandom_range(0, 127));
         access.address[8:3]  = ($urandom_range(0, 9) < 6) ? 6'($urandom_range(0, 7))
                                                            : 6'($urandom_range(0, 63));
         access.address[2:0]  = 3'($urandom_range(0, 7));
      end
      return access;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side backpressure
   initial begin
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reads.size() == 0) begin
            report_mismatch("response with no read pending", 64'h0, rsp_payload.line_data);
         end else begin
            want = pending_reads.pop_front();
            if (rsp_payload.line_data !== want.line_data)
               report_mismatch("line_data", want.line_data, rsp_payload.line_data);
            if (rsp_payload.hit !== want.hit)
               report_mismatch("hit", 64'(want.hit), 64'(rsp_payload.hit));
            if (rsp_payload.dirty_before !== want.dirty_before)
               report_mismatch("dirty_before", 64'(want.dirty_before),
                               64'(rsp_payload.dirty_before));
         end
      end
   end

   initial begin
      rsp_type        fixed_rsp;
      req_type        access;
      access_row_type row;
      bit             drain;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row                    = directed_rows[i];
         access.action          = row.action;
         access.address         = row.address;
         access.write_data      = row.write_data;
         fixed_rsp.line_data    = row.line_data;
         fixed_rsp.hit          = row.hit;
         fixed_rsp.dirty_before = row.dirty_before;
         send_access(access, row.fixed, fixed_rsp);
      end

      for (int n = 0; n < RANDOM_ACCESSES; n++) begin
         if (n % 100 == 0)
            idling_on = ($urandom_range(0, 3) != 0);
         if (n >= RANDOM_ACCESSES - QUIET_TAIL)
            idling_on = 1'b0;
         send_access(random_access(), 1'b0, '0);
         // pause now and then; at the drain points, hold off until every read in flight has answered
         drain = (n == RANDOM_ACCESSES / 3) || (n == 2 * RANDOM_ACCESSES / 3);
         if (drain || (idling_on && $urandom_range(0, 4) == 0)) begin
            req_valid <= 1'b0;
            if (idling_on)
               repeat ($urandom_range(1, 15)) @(posedge clock);
            else
               @(posedge clock);
            while (drain && pending_reads.size() != 0)
               @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      while (pending_reads.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule

// File: direct_mapped_writeback_cache_top.f
rtl/dmwc_pkg.sv
rtl/dmwc_ram.sv
rtl/dmwc_ctrl.sv
rtl/dmwc_datapath.sv
rtl/direct_mapped_writeback_cache_top.sv
tb/tb_top.sv
